/* rtl/obl_pkg.sv */
// Shared types and constants for the ordered block list unit.
// Depends on nothing; imported by the controller, the datapath and the top level.
package obl_pkg;

  localparam int ACT_W     = 3;
  localparam int OUT_ID_W  = 8;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND       = 3'd0,
    ACT_PREPEND      = 3'd1,
    ACT_REMOVE_FIRST = 3'd2,
    ACT_REMOVE_LAST  = 3'd3,
    ACT_REMOVE_ID    = 3'd4,
    ACT_MOVE_END     = 3'd5,
    ACT_MOVE_START   = 3'd6,
    ACT_CLEAR        = 3'd7
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the request and run the slot compare
    logic execute;  // apply the action to the list
  } obl_cmd_t;

endpackage

/* rtl/obl_ctrl.sv */
// Request sequencer of the ordered block list unit: capture, execute, report.
// Depends on obl_pkg for the command struct.
module obl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output obl_pkg::obl_cmd_t cmd_o
);
  import obl_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_EXEC);
    end
  end

  assign cmd_o.capture = start_i && (state_q == ST_IDLE);
  assign cmd_o.execute = (state_q == ST_EXEC);
  assign busy_o        = (state_q == ST_EXEC);
  assign done_o        = done_q;

endmodule

/* rtl/obl_datapath.sv */
// Slot register file, match compare and shift network of the ordered block list.
// Depends on obl_pkg for the action codes, command struct and port widths.
module obl_datapath #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  obl_pkg::obl_cmd_t              cmd_i,
  input  logic [obl_pkg::ACT_W-1:0]      action_i,
  input  logic [obl_pkg::OUT_ID_W-1:0]   block_id_i,
  output logic [obl_pkg::OUT_ID_W-1:0]   removed_id_o,
  output logic                           success_o,
  output logic                           list_empty_o,
  output logic [obl_pkg::OUT_CNT_W-1:0]  entry_count_o
);
  import obl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [ID_BITS-1:0]  slots_q [DEPTH];
  logic [ID_BITS-1:0]  slots_d [DEPTH];
  logic [CW-1:0]       count_q, count_d;
  action_e             act_q;
  logic [ID_BITS-1:0]  id_q;
  logic [DEPTH-1:0]    match_q;
  logic [ID_BITS-1:0]  last_q;
  logic [OUT_ID_W-1:0] removed_q, removed_d;
  logic                success_q, success_d;

  logic [ID_BITS+OUT_ID_W-1:0] id_wide;
  logic [ID_BITS-1:0]          id_in;
  logic [CW-1:0]               cnt_m1;
  logic [DEPTH-1:0]            match_d;
  logic [DEPTH-1:0]            above;
  logic [ID_BITS-1:0]          up_w [DEPTH];
  logic [ID_BITS-1:0]          dn_w [DEPTH];
  logic                        found, full, empty;
  logic [ID_BITS-1:0]          removed_val;
  logic [ID_BITS+OUT_ID_W-1:0] rem_wide;
  logic [CW+OUT_CNT_W-1:0]     cnt_wide;

  assign id_wide = {{ID_BITS{1'b0}}, block_id_i};
  assign id_in   = id_wide[ID_BITS-1:0];
  assign cnt_m1  = count_q - CW'(1);

  // Neighbour taps and the "a match lies below" mask.
  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    if (g == 0) begin : g_lo
      assign up_w[g] = id_q;
    end else begin : g_up
      assign up_w[g] = slots_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign dn_w[g] = slots_q[g];
    end else begin : g_dn
      assign dn_w[g] = slots_q[g+1];
    end
    assign above[g] = |(match_q & ~({DEPTH{1'b1}} << g));
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (slots_q[i] == id_in) && (CW'(i) < count_q);
    end
  end

  assign found = |match_q;
  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) slots_d[i] = slots_q[i];
    count_d     = count_q;
    removed_val = '0;
    success_d   = 1'b0;
    unique case (act_q)
      ACT_APPEND: if (!full) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) == count_q) slots_d[i] = id_q;
        end
        count_d   = count_q + CW'(1);
        success_d = 1'b1;
      end
      ACT_PREPEND: if (!full) begin
        for (int i = 0; i < DEPTH; i++) slots_d[i] = up_w[i];
        count_d   = count_q + CW'(1);
        success_d = 1'b1;
      end
      ACT_REMOVE_FIRST: if (!empty) begin
        for (int i = 0; i < DEPTH; i++) slots_d[i] = dn_w[i];
        removed_val = slots_q[0];
        count_d     = cnt_m1;
        success_d   = 1'b1;
      end
      ACT_REMOVE_LAST: if (!empty) begin
        removed_val = last_q;
        count_d     = cnt_m1;
        success_d   = 1'b1;
      end
      ACT_REMOVE_ID: if (found) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (above[i] || match_q[i]) slots_d[i] = dn_w[i];
        end
        removed_val = id_q;
        count_d     = cnt_m1;
        success_d   = 1'b1;
      end
      ACT_MOVE_END: if (found) begin
        // Close the gap, then drop the id into the last occupied slot.
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) == cnt_m1) slots_d[i] = id_q;
          else if (above[i] || match_q[i]) slots_d[i] = dn_w[i];
        end
        success_d = 1'b1;
      end
      ACT_MOVE_START: if (found) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!above[i]) slots_d[i] = up_w[i];
        end
        success_d = 1'b1;
      end
      ACT_CLEAR: begin
        count_d   = '0;
        success_d = 1'b1;
      end
    endcase
  end

  assign rem_wide  = {{OUT_ID_W{1'b0}}, removed_val};
  assign removed_d = rem_wide[OUT_ID_W-1:0];

  // Hold a known action from reset so the action decode never sees an unknown code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      act_q   <= ACT_CLEAR;
    end else begin
      if (cmd_i.execute) count_q <= count_d;
      if (cmd_i.capture) act_q <= action_e'(action_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q    <= id_in;
      match_q <= match_d;
      last_q  <= slots_q[cnt_m1[IW-1:0]];
    end
    if (cmd_i.execute) begin
      for (int i = 0; i < DEPTH; i++) slots_q[i] <= slots_d[i];
      removed_q <= removed_d;
      success_q <= success_d;
    end
  end

  assign cnt_wide      = {{OUT_CNT_W{1'b0}}, count_q};
  assign entry_count_o = cnt_wide[OUT_CNT_W-1:0];
  assign list_empty_o  = (count_q == '0);
  assign removed_id_o  = removed_q;
  assign success_o     = success_q;

endmodule

/* rtl/ordered_block_list_unit.sv */
// Top level of the ordered block list unit: replacement-order list of block ids.
// Depends on obl_pkg, obl_ctrl and obl_datapath.
//
// Usage:
//   A request (action_i, block_id_i) is taken at a rising edge with start_i
//   high and busy_o low. Actions: append, prepend, remove first, remove last,
//   remove id, move id to end, move id to start, clear. Position 0 is the
//   start of the list; remove id and the moves act on the first match.
//   The compare stage captures the request and compares every slot against
//   the id; the update stage then applies the shift or insert to the slot
//   registers and registers the response. done_o is then high for exactly
//   one cycle with removed_id_o, success_o, list_empty_o and entry_count_o
//   valid. busy_o is high for the one cycle in which the update stage runs,
//   and a new request may be issued in the done_o cycle.
//   The receiver cannot stall: sample the response when done_o is high.
//   Reset empties the list at once (count to zero); slot contents stay
//   undefined until written and are never read beyond the count, so no
//   clearing pass is needed.
module ordered_block_list_unit #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [obl_pkg::ACT_W-1:0]      action_i,
  input  logic [obl_pkg::OUT_ID_W-1:0]   block_id_i,
  output logic                           done_o,
  output logic [obl_pkg::OUT_ID_W-1:0]   removed_id_o,
  output logic                           success_o,
  output logic                           list_empty_o,
  output logic [obl_pkg::OUT_CNT_W-1:0]  entry_count_o
);
  import obl_pkg::*;

  obl_cmd_t cmd;

  // Sequence capture and execute for each request.
  obl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // Hold the slots and count; compare, shift and report.
  obl_datapath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .action_i      (action_i),
    .block_id_i    (block_id_i),
    .removed_id_o  (removed_id_o),
    .success_o     (success_o),
    .list_empty_o  (list_empty_o),
    .entry_count_o (entry_count_o)
  );

  // An accepted request occupies the unit for the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not raise busy");

  // Every execute cycle is followed by exactly one response strobe.
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> done_o && !busy_o)
    else $error("response strobe missing after execute");

  // A failed action leaves the count untouched.
  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !success_o |-> entry_count_o == $past(entry_count_o))
    else $error("count changed on a failed action");

  // A non-zero removed id is only reported on success.
  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (removed_id_o != '0) |-> success_o)
    else $error("removed id reported on a failed action");

endmodule
